@@ src/sat_pkg.sv @@
// Shared types and codes for the station association table.
package sat_pkg;

  localparam int MAC_W  = 48;
  localparam int CAPS_W = 3;
  localparam int SLEEP_W = 2;

  localparam logic [2:0] KIND_AUTH   = 3'd0;
  localparam logic [2:0] KIND_ASSOC  = 3'd1;
  localparam logic [2:0] KIND_DEAUTH = 3'd2;
  localparam logic [2:0] KIND_POWER  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_ARG     = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  localparam logic [1:0] SLEEP_DEFAULT   = 2'd0;
  localparam logic [1:0] SLEEP_AWAKE     = 2'd1;
  localparam logic [1:0] SLEEP_LOW_POWER = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [MAC_W-1:0] station_mac;
    logic             cap_aihs;
    logic             cap_sharing;
    logic             cap_vendor_station;
    logic             power_save;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] station_count;
    logic       slot_hit;
    logic [3:0] slot_index;
  } out_t;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [CAPS_W-1:0]  caps;
    logic [SLEEP_W-1:0] sleep;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ src/station_association_table.sv @@
// Top level of the station association table: sequencer, slot memory and active flags.
//
// Usage: one request per management event enters on the item channel
// (item_valid/item_stall/item); exactly one result per request leaves on the
// result channel (result_valid/result_stall/result).
// Requests are handled one at a time. Clear-table, auth, zero-MAC and
// unsupported requests skip the scan and go straight to the output state.
// Assoc, deauth and power requests scan the slot memory one slot at a time
// (read then compare), stopping at the first matching station or after the
// last of at most STATION_SLOTS slots, then pass through the update state.
// The slot memory has a single read port.
// Reset empties the table at once: the active flags are flip-flops, so the
// slot memory needs no clearing pass. While the receiver stalls, a finished
// result waits in the output register; a new request is still accepted and
// processed, and its result waits until the register is free.
module station_association_table #(
  parameter int STATION_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  sat_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output sat_pkg::out_t result
);

  import sat_pkg::*;

  localparam int IDX_W = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1;
  localparam int CNT_W = $clog2(STATION_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATION_SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]             state;
  in_t                    req;
  logic [STATION_SLOTS-1:0] active;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       scan_idx;
  logic                   match_found;
  logic [IDX_W-1:0]       match_idx;
  entry_t                 match_entry;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [1:0]             res_status;
  logic                   res_hit;
  logic [IDX_W-1:0]       res_idx;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  entry_t                 ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 rd_entry;
  logic                   accept;
  logic                   cmp_hit;
  logic                   out_free;
  out_t                   out_data;
  logic [CNT_W+4:0]       count_ext;
  logic [IDX_W+3:0]       idx_ext;
  logic [CAPS_W-1:0]      req_caps;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign rd_entry   = ram_rdata;
  assign cmp_hit    = active[scan_idx] && (rd_entry.mac == req.station_mac);
  assign req_caps   = {req.cap_vendor_station, req.cap_sharing, req.cap_aihs};

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STATION_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // Read-modify-write of the slot memory happens only in the update state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = match_idx;
    ram_wdata = match_entry;
    if (state == S_UPD) begin
      case (req.kind)
        KIND_ASSOC: begin
          if (match_found) begin
            ram_we         = 1'b1;
            ram_wdata.caps = req_caps;
          end else if (free_found) begin
            ram_we    = 1'b1;
            ram_waddr = free_idx;
            ram_wdata = '{mac: req.station_mac, caps: req_caps, sleep: SLEEP_DEFAULT};
          end
        end
        KIND_POWER: begin
          if (match_found) begin
            ram_we          = 1'b1;
            ram_wdata.sleep = req.power_save ? SLEEP_LOW_POWER : SLEEP_AWAKE;
          end
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
      count  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_CLEAR) begin
              active <= '0;
              count  <= '0;
              state  <= S_OUT;
            end else if (item.station_mac == '0) begin
              state <= S_OUT;
            end else if (item.kind == KIND_ASSOC || item.kind == KIND_DEAUTH ||
                         item.kind == KIND_POWER) begin
              state <= S_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (cmp_hit || scan_idx == LAST_IDX) begin
            state <= S_UPD;
          end else begin
            state <= S_RD;
          end
        end
        S_UPD: begin
          if (req.kind == KIND_ASSOC && !match_found && free_found) begin
            active[free_idx] <= 1'b1;
            count            <= count + 1'b1;
          end else if (req.kind == KIND_DEAUTH && match_found) begin
            active[match_idx] <= 1'b0;
            count             <= count - 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: request, scan progress and result fields.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        req         <= item;
        scan_idx    <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        res_hit     <= 1'b0;
        res_idx     <= '0;
        if (item.kind == KIND_CLEAR) begin
          res_status <= ST_OK;
        end else if (item.station_mac == '0) begin
          res_status <= ST_BAD_ARG;
        end else if (item.kind == KIND_AUTH || item.kind == KIND_ASSOC ||
                     item.kind == KIND_DEAUTH || item.kind == KIND_POWER) begin
          res_status <= ST_OK;
        end else begin
          res_status <= ST_UNSUPPORTED;
        end
      end
      S_CMP: begin
        if (cmp_hit) begin
          match_found <= 1'b1;
          match_idx   <= scan_idx;
          match_entry <= rd_entry;
        end else begin
          if (!active[scan_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= scan_idx;
          end
          if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
      end
      S_UPD: begin
        if (match_found) begin
          res_hit <= 1'b1;
          res_idx <= match_idx;
        end else if (req.kind == KIND_ASSOC && free_found) begin
          res_hit <= 1'b1;
          res_idx <= free_idx;
        end else if (req.kind == KIND_ASSOC) begin
          res_status <= ST_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext = {5'b0, count};
  assign idx_ext   = {4'b0, res_idx};

  always_comb begin
    out_data.status        = res_status;
    out_data.station_count = count_ext[4:0];
    out_data.slot_hit      = res_hit;
    out_data.slot_index    = idx_ext[3:0];
  end

  sat_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         ((state == S_OUT) && out_free),
    .load_data    (out_data),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STATION_SLOTS))
    else $error("station count exceeds the number of slots");

  a_count_matches_active: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(active)))
    else $error("station count does not match the active flags");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_CLEAR |=> active == '0 && count == '0)
    else $error("clear-table left active slots");

  a_match_is_active: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && match_found |-> active[match_idx])
    else $error("matched slot is not active");

endmodule

@@ src/sat_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/sat_outreg.sv @@
// Output register that holds one result until the receiver takes it.
module sat_outreg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  sat_pkg::out_t load_data,
  output logic          free,
  output logic          result_valid,
  input  logic          result_stall,
  output sat_pkg::out_t result
);

  import sat_pkg::*;

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

@@ test/tb_station_association_table.sv @@
// Self-checking testbench for the station association table.
module tb_station_association_table;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int STATION_SLOTS = 16;
  localparam int MAC_POOL = 24;
  localparam int RANDOM_ITEMS = 1950;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * STATION_SLOTS + 8;
  // Slowest legal run is about 2100 requests; the limit allows several times
  // its length.
  localparam longint unsigned LIMIT_NS = 64'd24_000_000;

  // Kinds above clear-table have no package name; they are all unsupported.
  localparam logic [2:0] KIND_UNSUP_LO = 3'd5;
  localparam logic [2:0] KIND_UNSUP_HI = 3'd7;

  localparam logic [MAC_W-1:0] MAC_ZERO = '0;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  in_t   item = '0;
  logic  result_valid;
  logic  result_stall = 1'b0;
  out_t  result;

  station_association_table #(
    .STATION_SLOTS(STATION_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predicted table contents.
  logic             sta_active [STATION_SLOTS];
  logic [MAC_W-1:0] sta_mac    [STATION_SLOTS];
  logic [2:0]       sta_caps   [STATION_SLOTS];
  logic [1:0]       sta_sleep  [STATION_SLOTS];

  out_t pending_results[$];
  logic [MAC_W-1:0] mac_pool [MAC_POOL];

  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned full_seen = 0;
  int unsigned bad_arg_seen = 0;
  int unsigned unsup_seen = 0;

  bit tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  function automatic void clear_table();
    for (int i = 0; i < STATION_SLOTS; i++) begin
      sta_active[i] = 1'b0;
      sta_mac[i] = '0;
      sta_caps[i] = '0;
      sta_sleep[i] = SLEEP_DEFAULT;
    end
  endfunction

  function automatic int find_station(logic [MAC_W-1:0] mac);
    int slot;
    slot = -1;
    for (int i = 0; i < STATION_SLOTS; i++)
      if (slot < 0 && sta_active[i] && sta_mac[i] == mac) slot = i;
    return slot;
  endfunction

  function automatic out_t predict_event(in_t ev);
    out_t r;
    int   slot;
    int   live;
    r = '0;
    slot = -1;
    live = 0;
    if (ev.kind == KIND_CLEAR) begin
      clear_table();
    end else if (ev.station_mac == MAC_ZERO) begin
      r.status = ST_BAD_ARG;
    end else begin
      case (ev.kind)
        KIND_AUTH: begin
        end
        KIND_ASSOC: begin
          slot = find_station(ev.station_mac);
          if (slot < 0) begin
            for (int i = 0; i < STATION_SLOTS; i++)
              if (slot < 0 && !sta_active[i]) slot = i;
            if (slot >= 0) begin
              sta_active[slot] = 1'b1;
              sta_mac[slot] = ev.station_mac;
              sta_sleep[slot] = SLEEP_DEFAULT;
            end
          end
          if (slot < 0) r.status = ST_FULL;
          else sta_caps[slot] = {ev.cap_vendor_station, ev.cap_sharing, ev.cap_aihs};
        end
        KIND_DEAUTH: begin
          slot = find_station(ev.station_mac);
          if (slot >= 0) begin
            sta_active[slot] = 1'b0;
            sta_mac[slot] = '0;
            sta_caps[slot] = '0;
            sta_sleep[slot] = SLEEP_DEFAULT;
          end
        end
        KIND_POWER: begin
          slot = find_station(ev.station_mac);
          if (slot >= 0) sta_sleep[slot] = ev.power_save ? SLEEP_LOW_POWER : SLEEP_AWAKE;
        end
        default: r.status = ST_UNSUPPORTED;
      endcase
    end
    for (int i = 0; i < STATION_SLOTS; i++)
      if (sta_active[i]) live++;
    r.station_count = 5'(live);
    r.slot_hit = (slot >= 0);
    r.slot_index = (slot >= 0) ? 4'(slot) : 4'd0;
    return r;
  endfunction

  function automatic in_t make_event(logic [2:0] kind, logic [MAC_W-1:0] mac,
                                     logic [2:0] caps, logic ps);
    in_t ev;
    ev.kind = kind;
    ev.station_mac = mac;
    ev.cap_aihs = caps[0];
    ev.cap_sharing = caps[1];
    ev.cap_vendor_station = caps[2];
    ev.power_save = ps;
    return ev;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [MAC_W-1:0] m;
    m[47:32] = 16'($urandom);
    m[31:0] = $urandom;
    return m;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Mostly traffic from a small pool of stations so the table fills and
  // entries get hit again; the rest is zero MACs, bad kinds and stray MACs.
  function automatic in_t random_event();
    in_t ev;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    ev = make_event(KIND_AUTH, mac_pool[$urandom_range(0, MAC_POOL - 1)],
                    3'($urandom), 1'($urandom));
    if (r < 85) begin
      if (k < 45) ev.kind = KIND_ASSOC;
      else if (k < 65) ev.kind = KIND_DEAUTH;
      else if (k < 85) ev.kind = KIND_POWER;
      else if (k < 97) ev.kind = KIND_AUTH;
      else ev.kind = KIND_CLEAR;
    end else if (r < 90) begin
      ev.kind = 3'($urandom);
      ev.station_mac = MAC_ZERO;
    end else if (r < 95) begin
      ev.kind = 3'($urandom_range(KIND_UNSUP_LO, KIND_UNSUP_HI));
      ev.station_mac = random_mac();
    end else begin
      ev.kind = 3'($urandom_range(KIND_AUTH, KIND_POWER));
      ev.station_mac = random_mac();
    end
    return ev;
  endfunction

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic send_event(input in_t ev);
    item <= ev;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(predict_event(ev));
    requests_sent++;
  endtask

  task automatic send_item(input in_t ev);
    int unsigned gap;
    send_event(ev);
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drops item_valid and waits on the clock until no result is pending, so the next request starts in a later step.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: a requested long hold takes priority over random stalls.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (rx_quiet) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.station_count !== want.station_count) begin
          $error("station_count: expected %0d, got %0d", want.station_count,
                 result.station_count);
          errors++;
        end
        if (result.slot_hit !== want.slot_hit) begin
          $error("slot_hit: expected %0d, got %0d", want.slot_hit, result.slot_hit);
          errors++;
        end
        if (result.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, result.slot_index);
          errors++;
        end
        if (want.slot_hit) hits_seen++;
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_BAD_ARG) bad_arg_seen++;
        if (want.status == ST_UNSUPPORTED) unsup_seen++;
      end
    end
  end

  task automatic test_empty_table();
    send_item(make_event(KIND_CLEAR, MAC_ZERO, 3'b000, 1'b0));
    send_item(make_event(KIND_AUTH, mac_pool[0], 3'b000, 1'b0));
    send_item(make_event(KIND_DEAUTH, mac_pool[0], 3'b000, 1'b0));
    send_item(make_event(KIND_POWER, mac_pool[0], 3'b111, 1'b1));
  endtask

  task automatic test_zero_mac();
    for (int k = KIND_AUTH; k <= KIND_UNSUP_HI; k++)
      if (3'(k) != KIND_CLEAR) send_item(make_event(3'(k), MAC_ZERO, 3'b111, 1'b1));
  endtask

  task automatic test_assoc_lifecycle();
    send_item(make_event(KIND_ASSOC, MAC_ONES, 3'b111, 1'b0));
    send_item(make_event(KIND_ASSOC, 48'd1, 3'b010, 1'b1));
    // Re-association of a known station keeps its slot.
    send_item(make_event(KIND_ASSOC, MAC_ONES, 3'b000, 1'b0));
    send_item(make_event(KIND_POWER, MAC_ONES, 3'b000, 1'b1));
    send_item(make_event(KIND_POWER, MAC_ONES, 3'b000, 1'b0));
    send_item(make_event(KIND_DEAUTH, MAC_ONES, 3'b000, 1'b0));
    // The freed lowest slot is taken again.
    send_item(make_event(KIND_ASSOC, mac_pool[1], 3'b101, 1'b0));
    send_item(make_event(3'd6, MAC_ONES, 3'b000, 1'b0));
    send_item(make_event(KIND_DEAUTH, MAC_ONES, 3'b000, 1'b0));
    wait_drained();
  endtask

  // The receiver holds off while the sender streams assocs back to back,
  // which also fills the table and runs into the full case.
  task automatic test_backpressure();
    send_item(make_event(KIND_CLEAR, mac_pool[2], 3'b000, 1'b0));
    wait_drained();
    hold_req <= hold_req + 1;
    tx_quiet = 1'b1;
    for (int i = 0; i < STATION_SLOTS + 3; i++)
      send_item(make_event(KIND_ASSOC, mac_pool[i], 3'($urandom), 1'b0));
    send_item(make_event(KIND_ASSOC, mac_pool[STATION_SLOTS / 2], 3'b110, 1'b0));
    send_item(make_event(KIND_DEAUTH, mac_pool[3], 3'b000, 1'b0));
    send_item(make_event(KIND_ASSOC, mac_pool[MAC_POOL - 1], 3'b001, 1'b0));
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Every so often run a stretch with no idling on either side.
      if (n % 250 == 100) begin
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
      end else if (n % 250 == 140) begin
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
      end
      send_item(random_event());
      // Occasionally let the table go fully idle before going on.
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
    wait_drained();
  endtask

  initial begin
    clear_table();
    for (int i = 0; i < MAC_POOL; i++) begin
      mac_pool[i] = random_mac();
      if (mac_pool[i] == MAC_ZERO) mac_pool[i] = 48'(i + 1);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_zero_mac();
    test_assoc_lifecycle();
    test_backpressure();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d results (%0d slot hits).",
             requests_sent, results_seen, hits_seen);
    $display("Table-full %0d, zero-MAC rejects %0d, unsupported kinds %0d.",
             full_seen, bad_arg_seen, unsup_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
